// ----- sv/cfpb_pkg.sv -----
// Shared types, widths, codes and axis-selection functions for the cube face
// projection block. No dependencies; imported by every module of the block.
package cfpb_pkg;

  localparam int POS_W     = 24;
  localparam int COMP_W    = POS_W + 1;
  localparam int DV_W      = POS_W;
  localparam int SUM_W     = 31;
  localparam int Q_W       = 20;
  localparam int FRAC_W    = 16;
  localparam int DEPTH_W   = 12;
  localparam int MAX_VERTS = 64;
  localparam int VIDX_W    = $clog2(MAX_VERTS);
  localparam int VCNT_W    = $clog2(MAX_VERTS + 1);
  localparam int VERT_W    = 3 * POS_W;
  localparam int FACE_W    = 3;
  localparam int NUM_FACES = 6;
  localparam int DIV_STEPS = Q_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int OUT_W     = 88;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FACE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } st_t;

  // Sign-extend one stored coordinate to component width.
  function automatic logic signed [COMP_W-1:0] ext(input logic [POS_W-1:0] a);
    ext = {a[POS_W-1], a};
  endfunction

  function automatic logic signed [COMP_W-1:0] vx(input logic [VERT_W-1:0] v);
    vx = ext(v[POS_W-1:0]);
  endfunction

  function automatic logic signed [COMP_W-1:0] vy(input logic [VERT_W-1:0] v);
    vy = ext(v[2*POS_W-1:POS_W]);
  endfunction

  function automatic logic signed [COMP_W-1:0] vz(input logic [VERT_W-1:0] v);
    vz = ext(v[3*POS_W-1:2*POS_W]);
  endfunction

  // s component of a vertex for a given face.
  function automatic logic signed [COMP_W-1:0] s_comp(input logic [VERT_W-1:0] v,
                                                     input logic [FACE_W-1:0] f);
    unique case (f)
      FACE_PX: s_comp = -vy(v);
      FACE_NX: s_comp = vy(v);
      FACE_PY: s_comp = vx(v);
      FACE_NY: s_comp = -vx(v);
      FACE_PZ: s_comp = -vy(v);
      FACE_NZ: s_comp = -vy(v);
      default: s_comp = '0;
    endcase
  endfunction

  // t component of a vertex for a given face.
  function automatic logic signed [COMP_W-1:0] t_comp(input logic [VERT_W-1:0] v,
                                                     input logic [FACE_W-1:0] f);
    unique case (f)
      FACE_PX, FACE_NX, FACE_PY, FACE_NY: t_comp = vz(v);
      FACE_PZ: t_comp = -vx(v);
      FACE_NZ: t_comp = vx(v);
      default: t_comp = '0;
    endcase
  endfunction

  // Depth component of a vertex for a given face, sign applied.
  function automatic logic signed [COMP_W-1:0] d_comp(input logic [VERT_W-1:0] v,
                                                     input logic [FACE_W-1:0] f);
    unique case (f)
      FACE_PX: d_comp = vx(v);
      FACE_NX: d_comp = -vx(v);
      FACE_PY: d_comp = vy(v);
      FACE_NY: d_comp = -vy(v);
      FACE_PZ: d_comp = vz(v);
      FACE_NZ: d_comp = -vz(v);
      default: d_comp = '0;
    endcase
  endfunction

endpackage

// ----- sv/cfpb_div.sv -----
// Bit-serial restoring divider giving a saturated Q3.16 quotient of
// (comp * 2^16) / dv, one quotient bit per cycle. Depends on cfpb_pkg.
module cfpb_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [cfpb_pkg::COMP_W-1:0] comp,
  input  logic [cfpb_pkg::DV_W-1:0]      dv,
  output logic                           done,
  output logic signed [cfpb_pkg::Q_W-1:0] quo_q
);
  import cfpb_pkg::*;

  logic [COMP_W-1:0] mag_c;
  logic [COMP_W-1:0] mag_hi;
  logic [DV_W-1:0]   rem;
  logic [DV_W-1:0]   divisor;
  logic [Q_W-1:0]    nbits;
  logic [Q_W-1:0]    quo;
  logic              neg;
  logic              ovf;
  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DV_W:0]     trial;
  logic [DV_W:0]     diff;
  logic              ge;

  // Magnitude of the numerator; the part of comp*2^16 from bit 20 up seeds the remainder.
  assign mag_c  = comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
  assign mag_hi = mag_c >> 4;

  // One restoring step.
  assign trial = {rem, nbits[Q_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  // Control: step counter and finish strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, numerator bits and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= DV_W'(mag_hi);
      divisor <= dv;
      nbits   <= {mag_c[3:0], {(Q_W-4){1'b0}}};
      quo     <= '0;
      neg     <= comp[COMP_W-1];
      ovf     <= mag_hi >= COMP_W'(dv);
    end else if (busy) begin
      rem   <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      nbits <= {nbits[Q_W-2:0], 1'b0};
      quo   <= {quo[Q_W-2:0], ge};
    end
  end

  // Apply sign and saturate to the Q3.16 range.
  always_comb begin
    if (ovf) begin
      quo_q = neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      quo_q = (quo > Q_W'(Q_MIN)) ? Q_MIN : Q_W'(-quo);
    end else begin
      quo_q = quo[Q_W-1] ? Q_MAX : Q_W'(quo);
    end
  end

endmodule

// ----- sv/cube_face_project_bounds.sv -----
// Top level: vertex buffer, axis sums, face choice, per-face bounds and control.
// Depends on cfpb_pkg and two cfpb_div serial dividers (s and t in parallel).
//
//  port group   | dir | carries
//  s_axis_*     | in  | tdata: pos_x,pos_y,pos_z; tuser: req_type; tlast: last_vertex
//  m_axis_*     | out | tdata: face,s_low,s_high,t_low,t_high,too_many_vertices
//  cfg_wr_*     | in  | min_depth write
//
// A vertex or clear word is taken while the block is idle. At the last vertex
// the block chooses the face, then for each vertex reads the memory and loads
// the operands; a projected vertex goes on to 20 steps of the serial dividers
// plus the finish strobe and then a bounds update. Last the block loads the
// result register. Input is not taken during that work.
// A result held by a stalled output does not block the next polygon's vertices.
// Reset is synchronous; it empties all bounds and restores min_depth to 1.
module cube_face_project_bounds (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cfpb_pkg::VERT_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic                         s_axis_tuser,  // req_type
  input  logic                         s_axis_tlast,  // last_vertex
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cfpb_pkg::OUT_W-1:0]   m_axis_tdata,  // face, s_low, s_high, t_low,
                                                      // t_high, too_many_vertices, pad
  input  logic                         cfg_wr_en,
  input  logic [cfpb_pkg::DEPTH_W-1:0] cfg_wr_data
);
  import cfpb_pkg::*;

  st_t state, state_next;

  logic [DEPTH_W-1:0] min_depth;
  logic [VCNT_W-1:0]  vcount;
  logic [VCNT_W-1:0]  idx;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic               ovf_seen;
  logic [FACE_W-1:0]  face_r;
  logic [FACE_W-1:0]  face_sel;

  logic [VERT_W-1:0]  vmem [MAX_VERTS];
  logic [VERT_W-1:0]  vrd;
  logic               vrd_en;

  logic signed [Q_W-1:0] s_lo [NUM_FACES];
  logic signed [Q_W-1:0] s_hi [NUM_FACES];
  logic signed [Q_W-1:0] t_lo [NUM_FACES];
  logic signed [Q_W-1:0] t_hi [NUM_FACES];

  logic in_acc, is_clear, out_free, last_idx;
  logic signed [COMP_W-1:0] dv_c, s_c, t_c;
  logic proj_ok, div_start, s_done, t_done;
  logic signed [Q_W-1:0] s_q, t_q;
  logic [SUM_W-1:0] ax, ay, az;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign is_clear = s_axis_tuser == REQ_CLEAR;
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign last_idx = (idx + 1'b1) >= vcount;

  // Face choice from the magnitudes of the summed axes; ties go to z.
  assign ax = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign ay = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
  assign az = sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);

  always_comb begin
    if (ax > ay && ax > az) begin
      face_sel = sum_x[SUM_W-1] ? FACE_NX : FACE_PX;
    end else if (ay > az && ay > ax) begin
      face_sel = sum_y[SUM_W-1] ? FACE_NY : FACE_PY;
    end else begin
      face_sel = sum_z[SUM_W-1] ? FACE_NZ : FACE_PZ;
    end
  end

  // Components of the buffered vertex for the chosen face, and the depth test.
  assign dv_c    = d_comp(vrd, face_r);
  assign s_c     = s_comp(vrd, face_r);
  assign t_c     = t_comp(vrd, face_r);
  assign proj_ok = ~dv_c[COMP_W-1] && (dv_c != '0) && (dv_c[DV_W-1:0] >= DV_W'(min_depth));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && !is_clear && s_axis_tlast) state_next = ST_FACE;
      ST_FACE: state_next = (vcount == '0) ? ST_OUT : ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: begin
        if (proj_ok) state_next = ST_DIV;
        else         state_next = last_idx ? ST_OUT : ST_READ;
      end
      ST_DIV:  if (s_done) state_next = ST_UPD;
      ST_UPD:  state_next = last_idx ? ST_OUT : ST_READ;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State-driven outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    vrd_en        = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_READ: vrd_en = 1'b1;
      ST_LOAD: div_start = proj_ok;
      ST_FACE, ST_DIV, ST_UPD, ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst)            min_depth <= DEPTH_W'(1);
    else if (cfg_wr_en) min_depth <= cfg_wr_data;
  end

  // Vertex buffer: written on accepted vertices while it has room, read with a registered port.
  always_ff @(posedge clk) begin
    if (in_acc && !is_clear && vcount < VCNT_W'(MAX_VERTS)) begin
      vmem[vcount[VIDX_W-1:0]] <= s_axis_tdata;
    end
    if (vrd_en) vrd <= vmem[idx[VIDX_W-1:0]];
  end

  // Polygon accumulation, walk index and end-of-polygon clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_z    <= '0;
      ovf_seen <= 1'b0;
      idx      <= '0;
    end else begin
      if (in_acc && !is_clear) begin
        if (vcount < VCNT_W'(MAX_VERTS)) begin
          vcount <= vcount + 1'b1;
          sum_x  <= sum_x + SUM_W'(vx(s_axis_tdata));
          sum_y  <= sum_y + SUM_W'(vy(s_axis_tdata));
          sum_z  <= sum_z + SUM_W'(vz(s_axis_tdata));
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if (state == ST_FACE) idx <= '0;
      if ((state == ST_LOAD && !proj_ok) || state == ST_UPD) idx <= idx + 1'b1;
      if (state == ST_OUT && out_free) begin
        vcount   <= '0;
        sum_x    <= '0;
        sum_y    <= '0;
        sum_z    <= '0;
        ovf_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FACE) face_r <= face_sel;
  end

  // Per-face bounds: emptied by reset or a clear word, widened after each division.
  always_ff @(posedge clk) begin
    if (rst || (in_acc && is_clear)) begin
      for (int f = 0; f < NUM_FACES; f++) begin
        s_lo[f] <= Q_MAX;
        s_hi[f] <= Q_MIN;
        t_lo[f] <= Q_MAX;
        t_hi[f] <= Q_MIN;
      end
    end else if (state == ST_UPD) begin
      if (s_q < s_lo[face_r]) s_lo[face_r] <= s_q;
      if (s_q > s_hi[face_r]) s_hi[face_r] <= s_q;
      if (t_q < t_lo[face_r]) t_lo[face_r] <= t_q;
      if (t_q > t_hi[face_r]) t_hi[face_r] <= t_q;
    end
  end

  // Serial dividers for s and t, run side by side.
  cfpb_div u_div_s (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .comp  (s_c),
    .dv    (dv_c[DV_W-1:0]),
    .done  (s_done),
    .quo_q (s_q)
  );

  cfpb_div u_div_t (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .comp  (t_c),
    .dv    (dv_c[DV_W-1:0]),
    .done  (t_done),
    .quo_q (t_q)
  );

  // Output register; the t divider finishes with the s divider, so its strobe
  // only guards the load.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free && !t_done) begin
      m_axis_tdata <= {4'b0, ovf_seen, t_hi[face_r], t_lo[face_r],
                       s_hi[face_r], s_lo[face_r], face_r};
    end
  end

endmodule
